FILE: rtl/core/srp_pkg.sv
// Shared types, sizes and codes of the shortest-request slot pool.
package srp_pkg;

	localparam int SLOTS       = 8;
	localparam int MAX_OPS     = 8;
	localparam int OP_WIDTH    = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int IN_W     = 16;
	localparam int OUT_OP_W = 16;
	localparam int SUM_W    = 19;
	localparam int IDX_W    = 3;
	localparam int OCNT_W   = 4;
	localparam int TDATA_W  = 48;

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(MAX_OPS + 1);
	localparam int ADDR_W  = (SLOTS * MAX_OPS > 1) ? $clog2(SLOTS * MAX_OPS) : 1;
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int EXT_W   = (OP_WIDTH > SUM_W) ? OP_WIDTH : SUM_W;

	typedef logic signed [OP_WIDTH-1:0] op_t;

	typedef enum logic {
		CMD_PRODUCE = 1'b0,
		CMD_CONSUME = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      last;
		op_t       value;
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_NONE = 2'd2,
		STATUS_OVER = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE    = 2'd0,
		SLOT_FILLING = 2'd1,
		SLOT_READY   = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_FILL = 2'd1,
		MODE_DROP = 2'd2
	} fill_mode_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_SEARCH = 2'd1,
		BK_PICK   = 2'd2,
		BK_EMIT   = 2'd3
	} back_state_t;

endpackage

FILE: rtl/core/shortest_request_slot_pool_core.sv
// Flow: a produce beat passes the command queue and then the pool engine, which registers
// its one result beat. A consume beat passes the queue, then the shortest-request scan over
// every slot, then the start of the operand read; its n result beats follow (a single beat
// from the pick step when nothing is ready). A new produce is taken every cycle while no
// consume is in progress and the output does not stall; consumes are bound by the scan and
// the single store read port. Reset is asynchronous.
module shortest_request_slot_pool_core
	import srp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // [15:0] operand_value
	input  logic               s_tuser,   // [0] action: 0 produce, 1 consume
	input  logic               s_tlast,   // request_last
	// Result channel.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [2:0] slot_index, [18:3] operand_out,
	                                      // [22:19] operand_count, [41:23] sum_out,
	                                      // [47:42] zero
	output logic [1:0]         m_tuser,   // [1:0] status
	output logic               m_tlast    // last_result
);

	// The front end classifies each beat and holds it in a short queue, so that the input
	// side can take beats while the engine scans or reads out, until the queue is full.
	// Reset frees every slot and empties the queue.
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	srp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// The back end owns all slot state and the operand store. Its result
	// register decouples it from a stalled output side.
	srp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: rtl/core/srp_front.sv
// Input side: accepts beats, sorts them into produce and consume commands and queues them.
module srp_front
	import srp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,   // operand_value
	input  logic            s_tuser,   // action
	input  logic            s_tlast,   // request_last
	output logic            cmd_valid,
	input  logic            cmd_pop,
	output cmd_t            cmd
);

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	cmd_t              incoming;

	assign s_tready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_pop && cmd_valid;

	// The operand is brought to the pool's storage width here, sign preserved.
	always_comb begin
		incoming.kind  = s_tuser ? CMD_CONSUME : CMD_PRODUCE;
		incoming.last  = s_tlast;
		incoming.value = OP_WIDTH'($signed(s_tdata));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/srp_back.sv
// Pool engine: slot bookkeeping, operand store, shortest-request search and result register.
module srp_back
	import srp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  cmd_t               cmd,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	// Operand store.
	op_t               mem [SLOTS * MAX_OPS];
	op_t               rdata_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	// Control state.
	back_state_t       state_q, state_d;
	fill_mode_t        mode_q, mode_d;
	logic [SLOT_W-1:0] fill_slot_q, fill_slot_d;
	logic [CNT_W-1:0]  fill_pos_q, fill_pos_d;
	slot_state_t       slot_state_q [SLOTS];
	slot_state_t       slot_state_d [SLOTS];
	logic [CNT_W-1:0]  slot_cnt_q [SLOTS];
	logic [CNT_W-1:0]  slot_cnt_d [SLOTS];
	logic [SLOT_W-1:0] scan_q, scan_d;
	logic              found_q, found_d;
	logic [CNT_W-1:0]  best_q, best_d;
	logic [SLOT_W-1:0] pick_q, pick_d;
	logic [CNT_W-1:0]  rd_pos_q, rd_pos_d;
	logic signed [SUM_W-1:0] acc_q, acc_d;

	// Result register.
	logic                       out_valid_q, out_valid_d;
	status_t                    out_status_q, out_status_d;
	logic [IDX_W-1:0]           out_slot_q, out_slot_d;
	logic signed [OUT_OP_W-1:0] out_op_q, out_op_d;
	logic [OCNT_W-1:0]          out_cnt_q, out_cnt_d;
	logic signed [SUM_W-1:0]    out_sum_q, out_sum_d;
	logic                       out_last_q, out_last_d;

	logic                    out_free;
	logic                    any_free;
	logic [SLOT_W-1:0]       free_idx;
	logic                    new_req;
	logic [SLOT_W-1:0]       eff_slot;
	logic [CNT_W-1:0]        eff_pos;
	logic [CNT_W-1:0]        pick_cnt;
	logic signed [EXT_W-1:0] rd_ext;
	logic signed [SUM_W-1:0] sum_next;

	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(TDATA_W - SUM_W - OCNT_W - OUT_OP_W - IDX_W)'(0),
		out_sum_q, out_cnt_q, out_op_q, out_slot_q};

	// Lowest free slot.
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_state_q[i] == SLOT_FREE) begin
				any_free = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign new_req  = (mode_q != MODE_FILL);
	assign eff_slot = new_req ? free_idx : fill_slot_q;
	assign eff_pos  = new_req ? '0 : fill_pos_q;
	assign pick_cnt = slot_cnt_q[pick_q];
	assign rd_ext   = EXT_W'(rdata_q);
	assign sum_next = acc_q + rd_ext[SUM_W-1:0];

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		fill_slot_d  = fill_slot_q;
		fill_pos_d   = fill_pos_q;
		slot_state_d = slot_state_q;
		slot_cnt_d   = slot_cnt_q;
		scan_d       = scan_q;
		found_d      = found_q;
		best_d       = best_q;
		pick_d       = pick_q;
		rd_pos_d     = rd_pos_q;
		acc_d        = acc_q;
		out_valid_d  = out_valid_q && !m_tready;
		out_status_d = out_status_q;
		out_slot_d   = out_slot_q;
		out_op_d     = out_op_q;
		out_cnt_d    = out_cnt_q;
		out_sum_d    = out_sum_q;
		out_last_d   = out_last_q;
		cmd_pop      = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = ADDR_W'(eff_slot) * ADDR_W'(MAX_OPS) + ADDR_W'(eff_pos);
		rd_en        = 1'b0;
		rd_addr      = ADDR_W'(pick_q) * ADDR_W'(MAX_OPS) + ADDR_W'(rd_pos_q);

		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_CONSUME) begin
					cmd_pop  = 1'b1;
					scan_d   = '0;
					found_d  = 1'b0;
					best_d   = '0;
					pick_d   = '0;
					state_d  = BK_SEARCH;
				end else if (cmd_valid && out_free) begin
					cmd_pop      = 1'b1;
					out_valid_d  = 1'b1;
					out_op_d     = '0;
					out_sum_d    = '0;
					out_last_d   = 1'b1;
					if (mode_q == MODE_DROP || (new_req && !any_free)) begin
						out_status_d = STATUS_FULL;
						out_slot_d   = '0;
						out_cnt_d    = '0;
						mode_d       = cmd.last ? MODE_IDLE : MODE_DROP;
					end else begin
						out_slot_d = IDX_W'(eff_slot);
						fill_slot_d = eff_slot;
						if (eff_pos < CNT_W'(MAX_OPS)) begin
							wr_en                  = 1'b1;
							fill_pos_d             = eff_pos + 1'b1;
							slot_cnt_d[eff_slot]   = eff_pos + 1'b1;
							out_status_d           = STATUS_OK;
							out_cnt_d              = OCNT_W'(eff_pos + 1'b1);
						end else begin
							fill_pos_d   = eff_pos;
							out_status_d = STATUS_OVER;
							out_cnt_d    = OCNT_W'(eff_pos);
						end
						if (cmd.last) begin
							slot_state_d[eff_slot] = SLOT_READY;
							mode_d                 = MODE_IDLE;
							fill_pos_d             = '0;
						end else begin
							slot_state_d[eff_slot] = SLOT_FILLING;
							mode_d                 = MODE_FILL;
						end
					end
				end
			end
			BK_SEARCH: begin
				if (slot_state_q[scan_q] == SLOT_READY &&
					(!found_q || slot_cnt_q[scan_q] < best_q)) begin
					found_d = 1'b1;
					best_d  = slot_cnt_q[scan_q];
					pick_d  = scan_q;
				end
				if (scan_q == SLOT_W'(SLOTS - 1)) begin
					state_d = BK_PICK;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			BK_PICK: begin
				if (!found_q || pick_cnt == '0) begin
					if (out_free) begin
						out_valid_d  = 1'b1;
						out_status_d = found_q ? STATUS_OK : STATUS_NONE;
						out_slot_d   = found_q ? IDX_W'(pick_q) : '0;
						out_op_d     = '0;
						out_cnt_d    = '0;
						out_sum_d    = '0;
						out_last_d   = 1'b1;
						if (found_q) begin
							slot_state_d[pick_q] = SLOT_FREE;
						end
						state_d = BK_IDLE;
					end
				end else begin
					// Start the read of the first operand; data is registered.
					rd_en    = 1'b1;
					rd_addr  = ADDR_W'(pick_q) * ADDR_W'(MAX_OPS);
					rd_pos_d = '0;
					acc_d    = '0;
					state_d  = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_status_d = STATUS_OK;
					out_slot_d   = IDX_W'(pick_q);
					out_op_d     = rd_ext[OUT_OP_W-1:0];
					out_cnt_d    = OCNT_W'(pick_cnt);
					acc_d        = sum_next;
					if ((rd_pos_q + 1'b1) == pick_cnt) begin
						out_sum_d            = sum_next;
						out_last_d           = 1'b1;
						slot_state_d[pick_q] = SLOT_FREE;
						slot_cnt_d[pick_q]   = '0;
						state_d              = BK_IDLE;
					end else begin
						out_sum_d  = '0;
						out_last_d = 1'b0;
						rd_en      = 1'b1;
						rd_addr    = ADDR_W'(pick_q) * ADDR_W'(MAX_OPS)
							+ ADDR_W'(rd_pos_q + 1'b1);
						rd_pos_d   = rd_pos_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			mode_q      <= MODE_IDLE;
			fill_slot_q <= '0;
			fill_pos_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_state_q[i] <= SLOT_FREE;
				slot_cnt_q[i]   <= '0;
			end
			scan_q      <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			pick_q      <= '0;
			rd_pos_q    <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			fill_slot_q  <= fill_slot_d;
			fill_pos_q   <= fill_pos_d;
			slot_state_q <= slot_state_d;
			slot_cnt_q   <= slot_cnt_d;
			scan_q       <= scan_d;
			found_q      <= found_d;
			best_q       <= best_d;
			pick_q       <= pick_d;
			rd_pos_q     <= rd_pos_d;
			acc_q        <= acc_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_status_q <= out_status_d;
		out_slot_q   <= out_slot_d;
		out_op_q     <= out_op_d;
		out_cnt_q    <= out_cnt_d;
		out_sum_q    <= out_sum_d;
		out_last_q   <= out_last_d;
	end

endmodule
